// File: hdl/c8alu_pkg.sv
`timescale 1ns / 1ps

package c8alu_pkg;

  // Operation codes; codes 19 to 31 act as a no-operation.
  typedef enum logic [4:0] {
    ACT_ADC    = 5'd0,
    ACT_SBC    = 5'd1,
    ACT_AND    = 5'd2,
    ACT_ORA    = 5'd3,
    ACT_EOR    = 5'd4,
    ACT_CMP    = 5'd5,
    ACT_ASL    = 5'd6,
    ACT_LSR    = 5'd7,
    ACT_ROL    = 5'd8,
    ACT_ROR    = 5'd9,
    ACT_INC    = 5'd10,
    ACT_DEC    = 5'd11,
    ACT_BIT    = 5'd12,
    ACT_BITIMM = 5'd13,
    ACT_TRB    = 5'd14,
    ACT_TSB    = 5'd15,
    ACT_LOAD   = 5'd16,
    ACT_RMB    = 5'd17,
    ACT_SMB    = 5'd18
  } action_e;

  // Status bit positions
  localparam int unsigned FLG_C = 0;
  localparam int unsigned FLG_Z = 1;
  localparam int unsigned FLG_D = 3;
  localparam int unsigned FLG_V = 6;
  localparam int unsigned FLG_N = 7;

  typedef struct packed {
    logic [4:0] action;
    logic [7:0] reg_value;
    logic [7:0] operand;
    logic [7:0] status_in;
    logic [2:0] bit_index;
  } c8alu_req_t;

  typedef struct packed {
    logic [7:0] result;
    logic [7:0] status_out;
  } c8alu_rsp_t;

endpackage

// File: hdl/c8alu_core.sv
`timescale 1ns / 1ps

module c8alu_core (
  input  c8alu_pkg::c8alu_req_t req_i,
  output c8alu_pkg::c8alu_rsp_t rsp_o
);

  logic [7:0] a;
  logic [7:0] b;
  logic [7:0] p;
  logic       cin;
  logic       dec_mode;

  // add with carry
  logic [4:0] lo_sum;
  logic [4:0] lo_adj;
  logic [8:0] dsum;
  logic [8:0] bsum;
  logic [8:0] psum;
  logic [9:0] dsum_fix;
  logic       add_v;
  logic [7:0] add_res;
  logic       add_c;

  // subtract with borrow
  logic [9:0] diff;
  logic [5:0] lo_diff;
  logic [7:0] dres;
  logic       sub_v;
  logic [7:0] sub_res;

  logic [8:0] cmp_diff;
  logic [7:0] bit_mask;
  logic       and_zero;

  logic [7:0] res;
  logic [7:0] st;
  logic       nz_en;
  logic [7:0] nz_src;

  assign a        = req_i.reg_value;
  assign b        = req_i.operand;
  assign p        = req_i.status_in;
  assign cin      = p[c8alu_pkg::FLG_C];
  assign dec_mode = p[c8alu_pkg::FLG_D];

  assign lo_sum   = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'b0, cin};
  assign lo_adj   = (lo_sum >= 5'd10) ? {1'b1, lo_sum[3:0] + 4'd6} : lo_sum;
  assign dsum     = {1'b0, a[7:4], 4'b0} + {1'b0, b[7:4], 4'b0} + {4'b0, lo_adj};
  assign bsum     = {1'b0, a} + {1'b0, b} + {8'b0, cin};
  assign psum     = dec_mode ? dsum : bsum;
  // V comes from the partial sum, before the high-digit adjust
  assign add_v    = ~(a[7] ^ b[7]) & (a[7] ^ psum[7]);
  assign dsum_fix = {1'b0, dsum} + ((dsum >= 9'h0a0) ? 10'h060 : 10'h000);
  assign add_res  = dec_mode ? dsum_fix[7:0] : bsum[7:0];
  assign add_c    = dec_mode ? (|dsum_fix[9:8]) : bsum[8];

  assign diff     = {2'b0, a} - {2'b0, b} - 10'd1 + {9'b0, cin};
  assign lo_diff  = {2'b0, a[3:0]} - {2'b0, b[3:0]} + {5'b0, cin} - 6'd1;
  assign sub_v    = (a[7] ^ b[7]) & (a[7] ^ diff[7]);
  assign dres     = diff[7:0] - (diff[9] ? 8'h60 : 8'h00) - (lo_diff[5] ? 8'h06 : 8'h00);
  assign sub_res  = dec_mode ? dres : diff[7:0];

  assign cmp_diff = {1'b0, a} - {1'b0, b};
  assign bit_mask = 8'b1 << req_i.bit_index;
  assign and_zero = ((a & b) == 8'h00);

  always_comb begin
    res    = a;
    st     = p;
    nz_en  = 1'b0;
    nz_src = 8'h00;
    unique case (req_i.action)
      c8alu_pkg::ACT_ADC: begin
        res                     = add_res;
        st[c8alu_pkg::FLG_V]    = add_v;
        st[c8alu_pkg::FLG_C]    = add_c;
        nz_en                   = 1'b1;
        nz_src                  = add_res;
      end
      c8alu_pkg::ACT_SBC: begin
        res                     = sub_res;
        st[c8alu_pkg::FLG_V]    = sub_v;
        st[c8alu_pkg::FLG_C]    = ~diff[9];
        nz_en                   = 1'b1;
        nz_src                  = sub_res;
      end
      c8alu_pkg::ACT_AND: begin
        res    = a & b;
        nz_en  = 1'b1;
        nz_src = a & b;
      end
      c8alu_pkg::ACT_ORA: begin
        res    = a | b;
        nz_en  = 1'b1;
        nz_src = a | b;
      end
      c8alu_pkg::ACT_EOR: begin
        res    = a ^ b;
        nz_en  = 1'b1;
        nz_src = a ^ b;
      end
      c8alu_pkg::ACT_CMP: begin
        st[c8alu_pkg::FLG_C] = ~cmp_diff[8];
        nz_en                = 1'b1;
        nz_src               = cmp_diff[7:0];
      end
      c8alu_pkg::ACT_ASL: begin
        res                  = {b[6:0], 1'b0};
        st[c8alu_pkg::FLG_C] = b[7];
        nz_en                = 1'b1;
        nz_src               = {b[6:0], 1'b0};
      end
      c8alu_pkg::ACT_LSR: begin
        res                  = {1'b0, b[7:1]};
        st[c8alu_pkg::FLG_C] = b[0];
        nz_en                = 1'b1;
        nz_src               = {1'b0, b[7:1]};
      end
      c8alu_pkg::ACT_ROL: begin
        res                  = {b[6:0], cin};
        st[c8alu_pkg::FLG_C] = b[7];
        nz_en                = 1'b1;
        nz_src               = {b[6:0], cin};
      end
      c8alu_pkg::ACT_ROR: begin
        res                  = {cin, b[7:1]};
        st[c8alu_pkg::FLG_C] = b[0];
        nz_en                = 1'b1;
        nz_src               = {cin, b[7:1]};
      end
      c8alu_pkg::ACT_INC: begin
        res    = b + 8'd1;
        nz_en  = 1'b1;
        nz_src = b + 8'd1;
      end
      c8alu_pkg::ACT_DEC: begin
        res    = b - 8'd1;
        nz_en  = 1'b1;
        nz_src = b - 8'd1;
      end
      c8alu_pkg::ACT_BIT: begin
        // N and V copy operand bits 7 and 6
        st[c8alu_pkg::FLG_N] = b[7];
        st[c8alu_pkg::FLG_V] = b[6];
        st[c8alu_pkg::FLG_Z] = and_zero;
      end
      c8alu_pkg::ACT_BITIMM: begin
        st[c8alu_pkg::FLG_Z] = and_zero;
      end
      c8alu_pkg::ACT_TRB: begin
        res                  = b & ~a;
        st[c8alu_pkg::FLG_Z] = and_zero;
      end
      c8alu_pkg::ACT_TSB: begin
        res                  = b | a;
        st[c8alu_pkg::FLG_Z] = and_zero;
      end
      c8alu_pkg::ACT_LOAD: begin
        res    = b;
        nz_en  = 1'b1;
        nz_src = b;
      end
      c8alu_pkg::ACT_RMB: begin
        res = b & ~bit_mask;
      end
      c8alu_pkg::ACT_SMB: begin
        res = b | bit_mask;
      end
      default: begin
        res = a;
      end
    endcase
    if (nz_en) begin
      st[c8alu_pkg::FLG_Z] = (nz_src == 8'h00);
      st[c8alu_pkg::FLG_N] = nz_src[7];
    end
  end

  assign rsp_o.result     = res;
  assign rsp_o.status_out = st;

endmodule

// File: hdl/cpu8_alu_with_bcd_flags.sv
`timescale 1ns / 1ps
// A taken request goes through the input register, then the result register, where
// out_valid_o rises; the single-pass ALU logic sits between the two registers.
// Throughput: one request per cycle while the output side does not stall.
// Stall from the output side holds the result register; one more request is still taken
// into the input register while the result waits.
// Reset (rst_ni low, asynchronous) clears both valid flags; payload registers are not reset.
module cpu8_alu_with_bcd_flags (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  c8alu_pkg::c8alu_req_t in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output c8alu_pkg::c8alu_rsp_t out_data_o
);

  logic                  req_valid_q;
  c8alu_pkg::c8alu_req_t req_q;
  logic                  rsp_valid_q;
  c8alu_pkg::c8alu_rsp_t rsp_q;
  c8alu_pkg::c8alu_rsp_t rsp_d;
  logic                  rsp_load;
  logic                  req_load;

  c8alu_core u_core (
    .req_i (req_q),
    .rsp_o (rsp_d)
  );

  // advance each stage when the one after it has room
  assign rsp_load   = ~rsp_valid_q | ~out_stall_i;
  assign req_load   = ~req_valid_q | rsp_load;
  assign in_stall_o = ~req_load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_valid_q <= 1'b0;
      rsp_valid_q <= 1'b0;
    end else begin
      if (req_load) begin
        req_valid_q <= in_valid_i;
      end
      if (rsp_load) begin
        rsp_valid_q <= req_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_load && in_valid_i) begin
      req_q <= in_data_i;
    end
    if (rsp_load && req_valid_q) begin
      rsp_q <= rsp_d;
    end
  end

  assign out_valid_o = rsp_valid_q;
  assign out_data_o  = rsp_q;

endmodule

// File: test/cpu8_alu_with_bcd_flags_check.sv
`timescale 1ns / 1ps

module cpu8_alu_with_bcd_flags_check
  import c8alu_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       in_stall_i,
  input  c8alu_req_t in_data_i,
  input  logic       out_valid_i,
  input  logic       out_stall_i,
  input  c8alu_rsp_t out_data_i,
  output int         fail_count_o,
  output int         pending_o
);

  c8alu_rsp_t alu_expected_q[$];

  initial fail_count_o = 0;
  initial pending_o = 0;

  function automatic c8alu_rsp_t alu_predict(c8alu_req_t req);
    logic [7:0]  a;
    logic [7:0]  b;
    logic [7:0]  r;
    logic [7:0]  p;
    logic [7:0]  nz_val;
    logic        nz_upd;
    logic        cin;
    logic [8:0]  ud;
    int unsigned lo;
    int unsigned sum;
    int          sdiff;
    int          slo;
    int          sadj;
    c8alu_rsp_t  rsp;
    a      = req.reg_value;
    b      = req.operand;
    p      = req.status_in;
    cin    = p[FLG_C];
    r      = a;
    nz_upd = 1'b1;
    case (req.action)
      ACT_ADC: begin
        if (p[FLG_D]) begin
          lo = int'(a[3:0]) + int'(b[3:0]) + int'(cin);
          if (lo >= 10) lo = ((lo + 6) & 15) + 16;
          sum = int'(a[7:4]) * 16 + int'(b[7:4]) * 16 + lo;
          // overflow comes from the partial sum, before the high digit fix
          p[FLG_V] = (a[7] == b[7]) && (a[7] != sum[7]);
          if (sum >= 160) sum = sum + 96;
        end else begin
          sum = int'(a) + int'(b) + int'(cin);
          p[FLG_V] = (a[7] == b[7]) && (a[7] != sum[7]);
        end
        p[FLG_C] = sum >= 256;
        r = sum[7:0];
      end
      ACT_SBC: begin
        sdiff = int'(a) - int'(b) - 1 + int'(cin);
        ud = sdiff[8:0];
        p[FLG_V] = (a[7] != b[7]) && (a[7] != ud[7]);
        p[FLG_C] = sdiff >= 0;
        if (p[FLG_D]) begin
          slo  = int'(a[3:0]) - int'(b[3:0]) + int'(cin) - 1;
          sadj = sdiff;
          if (sadj < 0) sadj = sadj - 96;
          if (slo < 0) sadj = sadj - 6;
          r = sadj[7:0];
        end else begin
          r = ud[7:0];
        end
      end
      ACT_AND: r = a & b;
      ACT_ORA: r = a | b;
      ACT_EOR: r = a ^ b;
      ACT_CMP: begin
        p[FLG_C] = a >= b;
      end
      ACT_ASL: begin
        p[FLG_C] = b[7];
        r = {b[6:0], 1'b0};
      end
      ACT_LSR: begin
        p[FLG_C] = b[0];
        r = {1'b0, b[7:1]};
      end
      ACT_ROL: begin
        p[FLG_C] = b[7];
        r = {b[6:0], cin};
      end
      ACT_ROR: begin
        p[FLG_C] = b[0];
        r = {cin, b[7:1]};
      end
      ACT_INC: r = b + 8'd1;
      ACT_DEC: r = b - 8'd1;
      ACT_BIT: begin
        p[FLG_N] = b[7];
        p[FLG_V] = b[6];
        p[FLG_Z] = (a & b) == 8'h00;
        nz_upd = 1'b0;
      end
      ACT_BITIMM: begin
        p[FLG_Z] = (a & b) == 8'h00;
        nz_upd = 1'b0;
      end
      ACT_TRB: begin
        p[FLG_Z] = (a & b) == 8'h00;
        r = b & ~a;
        nz_upd = 1'b0;
      end
      ACT_TSB: begin
        p[FLG_Z] = (a & b) == 8'h00;
        r = b | a;
        nz_upd = 1'b0;
      end
      ACT_LOAD: r = b;
      ACT_RMB: begin
        r = b;
        r[req.bit_index] = 1'b0;
        nz_upd = 1'b0;
      end
      ACT_SMB: begin
        r = b;
        r[req.bit_index] = 1'b1;
        nz_upd = 1'b0;
      end
      default: nz_upd = 1'b0;
    endcase
    // compare flags come from the difference but the register stays
    nz_val = (req.action == ACT_CMP) ? a - b : r;
    if (nz_upd) begin
      p[FLG_Z] = nz_val == 8'h00;
      p[FLG_N] = nz_val[7];
    end
    rsp.result     = r;
    rsp.status_out = p;
    return rsp;
  endfunction

  always @(posedge clk_i) begin : watch
    c8alu_rsp_t exp_rsp;
    int         errs;
    if (rst_ni) begin
      errs = 0;
      if (out_valid_i && !out_stall_i) begin
        if (alu_expected_q.size() == 0) begin
          $error("unexpected result: result %h status_out %h",
                 out_data_i.result, out_data_i.status_out);
          errs++;
        end else begin
          exp_rsp = alu_expected_q.pop_front();
          if (out_data_i.result !== exp_rsp.result) begin
            $error("result mismatch: expected %h, actual %h",
                   exp_rsp.result, out_data_i.result);
            errs++;
          end
          if (out_data_i.status_out !== exp_rsp.status_out) begin
            $error("status_out mismatch: expected %h, actual %h",
                   exp_rsp.status_out, out_data_i.status_out);
            errs++;
          end
        end
      end
      if (in_valid_i && !in_stall_i) alu_expected_q.push_back(alu_predict(in_data_i));
      pending_o = alu_expected_q.size();
      if (errs != 0) fail_count_o <= fail_count_o + errs;
    end
  end

endmodule

// File: test/cpu8_alu_with_bcd_flags_test.sv
`timescale 1ns / 1ps

module cpu8_alu_with_bcd_flags_test;
  import c8alu_pkg::*;

  localparam int         RANDOM_REQS = 1500;
  localparam int         CYCLE_LIMIT = 400000;
  localparam logic [7:0] ST_C        = 8'(1 << FLG_C);
  localparam logic [7:0] ST_D        = 8'(1 << FLG_D);
  localparam int         ACT_TOP     = (1 << $bits(action_e)) - 1;

  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       in_valid_i  = 1'b0;
  logic       in_stall_o;
  c8alu_req_t in_data_i   = '0;
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  c8alu_rsp_t out_data_o;

  int          fail_cnt;
  int          pending_cnt;
  int          cycle_cnt  = 0;
  int unsigned sink_hold  = 0;
  bit          burst_mode = 1'b0;

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  cpu8_alu_with_bcd_flags u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  cpu8_alu_with_bcd_flags_check u_check (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_i  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_i (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_i  (out_data_o),
    .fail_count_o(fail_cnt),
    .pending_o   (pending_cnt)
  );

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // hold the result side off for a random count after each taken result
  always @(posedge clk_i) begin : sink_pace
    int unsigned hold;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      sink_hold   <= 0;
    end else if (out_valid_o && !out_stall_i) begin
      hold = burst_mode ? 0 : $urandom_range(0, 11);
      sink_hold   <= hold;
      out_stall_i <= hold != 0;
    end else if (sink_hold != 0) begin
      sink_hold   <= sink_hold - 1;
      out_stall_i <= sink_hold > 1;
    end
  end

  function automatic c8alu_req_t mk_req(action_e act, logic [7:0] a, logic [7:0] b,
                                        logic [7:0] p, logic [2:0] idx);
    c8alu_req_t req;
    req.action    = act;
    req.reg_value = a;
    req.operand   = b;
    req.status_in = p;
    req.bit_index = idx;
    return req;
  endfunction

  function automatic logic [7:0] rand_bcd();
    logic [3:0] hi;
    logic [3:0] lo;
    hi = 4'($urandom_range(0, 9));
    lo = 4'($urandom_range(0, 9));
    return {hi, lo};
  endfunction

  // valid stays high across back-to-back requests; drop it only for a gap
  task automatic send_req(input c8alu_req_t req);
    int unsigned gap;
    gap = burst_mode ? 0 : $urandom_range(0, 11);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= req;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  initial begin
    c8alu_req_t req;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // binary and decimal carry, overflow and borrow corners
    send_req(mk_req(ACT_ADC, 8'hff, 8'h01, 8'h00, 3'd0));
    send_req(mk_req(ACT_ADC, 8'h7f, 8'h01, 8'hff & ~ST_D & ~ST_C, 3'd0));
    send_req(mk_req(ACT_ADC, 8'h99, 8'h01, ST_D, 3'd0));
    send_req(mk_req(ACT_ADC, 8'h0f, 8'h0f, ST_D | ST_C, 3'd0));
    send_req(mk_req(ACT_ADC, 8'h79, 8'h10, ST_D, 3'd0));
    send_req(mk_req(ACT_SBC, 8'h00, 8'h01, ST_C, 3'd0));
    send_req(mk_req(ACT_SBC, 8'h80, 8'h01, ST_C, 3'd0));
    send_req(mk_req(ACT_SBC, 8'h00, 8'h01, ST_D | ST_C, 3'd0));
    send_req(mk_req(ACT_SBC, 8'hff, 8'hff, 8'hff & ~ST_C, 3'd7));
    send_req(mk_req(ACT_AND, 8'hff, 8'h00, 8'h00, 3'd0));
    send_req(mk_req(ACT_ORA, 8'h80, 8'h01, 8'hff, 3'd0));
    send_req(mk_req(ACT_EOR, 8'hff, 8'hff, 8'h00, 3'd0));
    send_req(mk_req(ACT_CMP, 8'h40, 8'h40, 8'h00, 3'd0));
    send_req(mk_req(ACT_CMP, 8'h00, 8'hff, 8'hff, 3'd0));
    send_req(mk_req(ACT_ASL, 8'h00, 8'h80, 8'h00, 3'd0));
    send_req(mk_req(ACT_LSR, 8'h00, 8'h01, 8'h00, 3'd0));
    send_req(mk_req(ACT_ROL, 8'h00, 8'h80, ST_C, 3'd0));
    send_req(mk_req(ACT_ROR, 8'h00, 8'h01, ST_C, 3'd0));
    send_req(mk_req(ACT_INC, 8'h00, 8'hff, 8'h00, 3'd0));
    send_req(mk_req(ACT_DEC, 8'h00, 8'h00, 8'h00, 3'd0));
    send_req(mk_req(ACT_BIT, 8'h3f, 8'hc0, 8'h00, 3'd0));
    send_req(mk_req(ACT_BITIMM, 8'hff, 8'h00, 8'h00, 3'd0));
    send_req(mk_req(ACT_TRB, 8'h0f, 8'hff, 8'hff, 3'd0));
    send_req(mk_req(ACT_TSB, 8'hf0, 8'h0f, 8'h00, 3'd0));
    send_req(mk_req(ACT_LOAD, 8'hff, 8'h00, 8'hff, 3'd0));
    send_req(mk_req(ACT_RMB, 8'h00, 8'hff, 8'h00, 3'd7));
    send_req(mk_req(ACT_SMB, 8'hff, 8'h00, 8'hff, 3'd0));
    // unused codes pass everything through
    req = mk_req(ACT_ADC, 8'h5a, 8'ha5, 8'hff, 3'd5);
    req.action = 5'(int'(ACT_SMB) + 1);
    send_req(req);
    req.action = 5'(ACT_TOP);
    send_req(req);

    for (int i = 0; i < RANDOM_REQS; i++) begin
      if ($urandom_range(0, 63) == 0) burst_mode = !burst_mode;
      if ($urandom_range(0, 9) == 0) req.action = 5'($urandom_range(int'(ACT_SMB) + 1, ACT_TOP));
      else req.action = 5'($urandom_range(0, int'(ACT_SMB)));
      req.reg_value = 8'($urandom);
      req.operand   = 8'($urandom);
      req.status_in = 8'($urandom);
      req.bit_index = 3'($urandom);
      // favor valid decimal digits for add and subtract
      if ((req.action == ACT_ADC || req.action == ACT_SBC) && $urandom_range(0, 2) != 0) begin
        req.status_in[FLG_D] = 1'b1;
        req.reg_value = rand_bcd();
        req.operand   = rand_bcd();
      end
      send_req(req);
    end
    in_valid_i <= 1'b0;
    // let the checker record the last request before draining
    @(posedge clk_i);

    wait (pending_cnt == 0);
    repeat (8) @(posedge clk_i);
    if (fail_cnt == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
